/* rtl/best_fit_block_pool_core_macros.svh */
// Assertion macros for the best-fit block pool checker.
// Depends on nothing; included by the checker file.
`ifndef BEST_FIT_BLOCK_POOL_CORE_MACROS_SVH
`define BEST_FIT_BLOCK_POOL_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFBP_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFBP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/bfbp_pkg.sv */
// Shared types and codes of the best-fit block pool.
// No dependencies; used by the interfaces, the core and the checker.
package bfbp_pkg;

	// Fixed field widths of the command and result transactions.
	localparam int ACTION_W = 2;
	localparam int REQ_W    = 32;
	localparam int SLOT_W   = 4;
	localparam int STATUS_W = 4;
	localparam int TOTAL_W  = 36;
	localparam int COUNT_W  = 5;
	localparam int EVENT_W  = 32;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [EVENT_W-1:0] EVENT_MAX = {EVENT_W{1'b1}};

	// Command actions.
	localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_RESET   = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_TRIM    = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_REUSED   = 4'd0;
	localparam logic [STATUS_W-1:0] ST_NEW      = 4'd1;
	localparam logic [STATUS_W-1:0] ST_RELEASED = 4'd2;
	localparam logic [STATUS_W-1:0] ST_RESET    = 4'd3;
	localparam logic [STATUS_W-1:0] ST_TRIMMED  = 4'd4;
	localparam logic [STATUS_W-1:0] ST_ZERO     = 4'd5;
	localparam logic [STATUS_W-1:0] ST_FULL     = 4'd6;
	localparam logic [STATUS_W-1:0] ST_DOUBLE   = 4'd7;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 4'd8;

	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [TOTAL_W-1:0]  total_t;
	typedef logic [EVENT_W-1:0]  event_cnt_t;

endpackage

/* rtl/bfbp_if.sv */
// Valid/ready channel interfaces for the command and result transactions.
// Depends on bfbp_pkg for the field widths.
interface bfbp_cmd_if import bfbp_pkg::*; ();
	logic              valid;
	logic              ready;
	action_t           action;
	logic [REQ_W-1:0]  request_size;
	logic [SLOT_W-1:0] slot;

	modport source (output valid, action, request_size, slot, input ready);
	modport sink (input valid, action, request_size, slot, output ready);
endinterface

interface bfbp_res_if import bfbp_pkg::*; ();
	logic               valid;
	logic               ready;
	status_t            status;
	logic [SLOT_W-1:0]  granted_slot;
	logic [REQ_W-1:0]   granted_size;
	total_t             pool_bytes;
	total_t             used_bytes;
	logic [COUNT_W-1:0] block_count;
	logic [COUNT_W-1:0] free_block_count;
	event_cnt_t         grant_count;
	event_cnt_t         reuse_count;

	modport source (output valid, status, granted_slot, granted_size, pool_bytes,
		used_bytes, block_count, free_block_count, grant_count, reuse_count,
		input ready);
	modport sink (input valid, status, granted_slot, granted_size, pool_bytes,
		used_bytes, block_count, free_block_count, grant_count, reuse_count,
		output ready);
endinterface

/* rtl/best_fit_block_pool_core.sv */
// Best-fit block pool. Allocate and trim scan the size RAM one entry a cycle, then pass
// S_LAST and S_DECIDE before the result is offered; release reads its slot in S_REL,
// and zero size, oversize, unknown slot, double release and reset pool skip to S_OUT.
// One transaction at a time: the next command is accepted the cycle after the result loads.
// Reset clears all marks, totals and counters at once; the size RAM is not cleared.
// Depends on bfbp_pkg, bfbp_if and bfbp_ram.
module best_fit_block_pool_core import bfbp_pkg::*; #(
	parameter int MAX_BLOCKS = 16,
	parameter int SIZE_BITS  = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	bfbp_cmd_if.sink   cmd,
	bfbp_res_if.source res
);

	localparam int IW    = $clog2(MAX_BLOCKS);
	localparam int CW    = $clog2(MAX_BLOCKS + 1);
	localparam int SUM_W = ((SIZE_BITS > TOTAL_W) ? SIZE_BITS : TOTAL_W) + 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_LAST   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_REL    = 3'd4;
	localparam logic [2:0] S_OUT    = 3'd5;

	typedef logic [SIZE_BITS-1:0] bytes_t;
	typedef logic [IW-1:0]        idx_t;
	typedef logic [CW-1:0]        cnt_t;

	logic [2:0]            state_q;
	action_t               act_q;
	bytes_t                req_q;
	idx_t                  slot_q;
	status_t               status_q;
	idx_t                  gslot_q;
	bytes_t                gsize_q;
	logic [MAX_BLOCKS-1:0] valid_q;
	logic [MAX_BLOCKS-1:0] busy_q;
	total_t                pool_q;
	total_t                used_q;
	event_cnt_t            grants_q;
	event_cnt_t            reuses_q;
	cnt_t                  nblk_q;
	cnt_t                  nfree_q;
	idx_t                  rd_idx_q;
	logic                  scan_v_s1;
	idx_t                  idx_s1;
	logic                  best_f_q;
	idx_t                  best_idx_q;
	bytes_t                best_bytes_q;
	logic                  empty_f_q;
	idx_t                  empty_idx_q;
	logic                  res_valid_q;

	logic   cmd_fire;
	logic   out_load;
	idx_t   cmd_slot_idx;
	logic   slot_range_bad;
	logic   oversize;
	logic   ram_rd_en;
	idx_t   ram_rd_addr;
	bytes_t ram_rd_data;
	logic   ram_wr_en;

	// Saturating arithmetic on the 36-bit byte totals.
	function automatic total_t sat_add(total_t a, bytes_t b);
		logic [SUM_W-1:0] s;
		s = SUM_W'(a) + SUM_W'(b);
		return (s > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : s[TOTAL_W-1:0];
	endfunction

	function automatic total_t sat_sub(total_t a, bytes_t b);
		logic [SUM_W-1:0] d;
		d = SUM_W'(a) - SUM_W'(b);
		return (SUM_W'(b) > SUM_W'(a)) ? '0 : d[TOTAL_W-1:0];
	endfunction

	function automatic event_cnt_t inc_sat(event_cnt_t c);
		return (c == EVENT_MAX) ? c : c + 1'b1;
	endfunction

	// Handshake and command decode.
	assign cmd.ready      = (state_q == S_IDLE);
	assign cmd_fire       = cmd.valid && cmd.ready;
	assign cmd_slot_idx   = IW'(cmd.slot);
	assign slot_range_bad = (32'(cmd.slot) >= 32'(MAX_BLOCKS));
	assign oversize       = ((cmd.request_size >> SIZE_BITS) != '0);
	assign out_load       = (state_q == S_OUT) && (!res_valid_q || res.ready);

	// Size RAM access: the scan reads in order, release reads its slot.
	assign ram_rd_en   = (state_q == S_SCAN) || cmd_fire;
	assign ram_rd_addr = (state_q == S_SCAN) ? rd_idx_q : cmd_slot_idx;
	assign ram_wr_en   = (state_q == S_DECIDE) && (act_q == ACT_ALLOC) &&
		!best_f_q && empty_f_q;

	bfbp_ram #(
		.WIDTH(SIZE_BITS),
		.DEPTH(MAX_BLOCKS)
	) u_size_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (empty_idx_q),
		.wr_data (req_q),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Per-transaction payload registers.
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			act_q   <= cmd.action;
			req_q   <= SIZE_BITS'(cmd.request_size);
			slot_q  <= cmd_slot_idx;
			gslot_q <= '0;
			gsize_q <= '0;
		end else if (state_q == S_DECIDE && act_q == ACT_ALLOC) begin
			if (best_f_q) begin
				gslot_q <= best_idx_q;
				gsize_q <= best_bytes_q;
			end else if (empty_f_q) begin
				gslot_q <= empty_idx_q;
				gsize_q <= req_q;
			end
		end else if (state_q == S_REL) begin
			gslot_q <= slot_q;
		end
		if (scan_v_s1) begin
			if (valid_q[idx_s1]) begin
				if (!busy_q[idx_s1] && ram_rd_data >= req_q &&
					(!best_f_q || ram_rd_data < best_bytes_q)) begin
					best_idx_q   <= idx_s1;
					best_bytes_q <= ram_rd_data;
				end
			end else if (!empty_f_q) begin
				empty_idx_q <= idx_s1;
			end
		end
	end

	// Sequencer, block marks, totals and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			status_q  <= ST_RESET;
			valid_q   <= '0;
			busy_q    <= '0;
			pool_q    <= '0;
			used_q    <= '0;
			grants_q  <= '0;
			reuses_q  <= '0;
			nblk_q    <= '0;
			nfree_q   <= '0;
			rd_idx_q  <= '0;
			scan_v_s1 <= 1'b0;
			idx_s1    <= '0;
			best_f_q  <= 1'b0;
			empty_f_q <= 1'b0;
		end else begin
			scan_v_s1 <= (state_q == S_SCAN);
			idx_s1    <= rd_idx_q;

			// Compare or trim the entry whose size arrives from the RAM.
			if (scan_v_s1 && valid_q[idx_s1]) begin
				if (act_q == ACT_ALLOC) begin
					if (!busy_q[idx_s1] && ram_rd_data >= req_q &&
						(!best_f_q || ram_rd_data < best_bytes_q)) begin
						best_f_q <= 1'b1;
					end
				end else if (!busy_q[idx_s1]) begin
					valid_q[idx_s1] <= 1'b0;
					pool_q          <= sat_sub(pool_q, ram_rd_data);
					nblk_q          <= nblk_q - 1'b1;
					nfree_q         <= nfree_q - 1'b1;
				end
			end else if (scan_v_s1) begin
				empty_f_q <= 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						best_f_q  <= 1'b0;
						empty_f_q <= 1'b0;
						rd_idx_q  <= '0;
						state_q   <= S_OUT;
						case (cmd.action)
							ACT_ALLOC: begin
								if (cmd.request_size == '0) begin
									status_q <= ST_ZERO;
								end else if (oversize) begin
									status_q <= ST_FULL;
								end else begin
									state_q <= S_SCAN;
								end
							end
							ACT_RELEASE: begin
								if (slot_range_bad || !valid_q[cmd_slot_idx]) begin
									status_q <= ST_UNKNOWN;
								end else if (!busy_q[cmd_slot_idx]) begin
									status_q <= ST_DOUBLE;
								end else begin
									state_q <= S_REL;
								end
							end
							ACT_RESET: begin
								status_q <= ST_RESET;
								valid_q  <= '0;
								busy_q   <= '0;
								pool_q   <= '0;
								used_q   <= '0;
								grants_q <= '0;
								reuses_q <= '0;
								nblk_q   <= '0;
								nfree_q  <= '0;
							end
							default: begin
								status_q <= ST_TRIMMED;
								state_q  <= S_SCAN;
							end
						endcase
					end
				end
				S_SCAN: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					if (rd_idx_q == IW'(MAX_BLOCKS - 1)) begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					// For an allocation: grant the best fit, else make a new block, else report full.
					state_q <= S_OUT;
					if (act_q == ACT_ALLOC) begin
						if (best_f_q) begin
							status_q             <= ST_REUSED;
							busy_q[best_idx_q]   <= 1'b1;
							used_q               <= sat_add(used_q, best_bytes_q);
							reuses_q             <= inc_sat(reuses_q);
							grants_q             <= inc_sat(grants_q);
							nfree_q              <= nfree_q - 1'b1;
						end else if (empty_f_q) begin
							status_q             <= ST_NEW;
							valid_q[empty_idx_q] <= 1'b1;
							busy_q[empty_idx_q]  <= 1'b1;
							pool_q               <= sat_add(pool_q, req_q);
							used_q               <= sat_add(used_q, req_q);
							grants_q             <= inc_sat(grants_q);
							nblk_q               <= nblk_q + 1'b1;
						end else begin
							status_q <= ST_FULL;
						end
					end
				end
				S_REL: begin
					status_q       <= ST_RELEASED;
					busy_q[slot_q] <= 1'b0;
					used_q         <= sat_sub(used_q, ram_rd_data);
					nfree_q        <= nfree_q + 1'b1;
					state_q        <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result register: holds a finished transaction until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res.status           <= status_q;
			res.granted_slot     <= SLOT_W'(gslot_q);
			res.granted_size     <= REQ_W'(gsize_q);
			res.pool_bytes       <= pool_q;
			res.used_bytes       <= used_q;
			res.block_count      <= COUNT_W'(nblk_q);
			res.free_block_count <= COUNT_W'(nfree_q);
			res.grant_count      <= grants_q;
			res.reuse_count      <= reuses_q;
		end
	end

	assign res.valid = res_valid_q;

endmodule

/* rtl/bfbp_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module bfbp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/bfbp_checker.sv */
// Port-level assertions for best_fit_block_pool_core, with the bind that attaches them.
// Depends on bfbp_pkg and best_fit_block_pool_core_macros.svh.
`include "best_fit_block_pool_core_macros.svh"

module bfbp_checker import bfbp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_ready,
	input logic               res_valid,
	input logic               res_ready,
	input status_t            res_status,
	input logic [REQ_W-1:0]   res_granted_size,
	input logic [COUNT_W-1:0] res_block_count,
	input logic [COUNT_W-1:0] res_free_block_count
);

	// A stalled result transaction stays offered with the same status.
	`BFBP_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_status), "result dropped while stalled")

	// One command at a time: the core is busy right after accepting one.
	`BFBP_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready, "command accepted while busy")

	// Free blocks are a subset of the valid blocks.
	`BFBP_ASSERT_NOW(a_free_le_blocks, clk, arst_n, res_valid, res_free_block_count <= res_block_count, "more free blocks than blocks")

	// Only a grant carries a size.
	`BFBP_ASSERT_NOW(a_size_on_grant, clk, arst_n, res_valid && res_status != ST_REUSED && res_status != ST_NEW, res_granted_size == '0, "size reported without a grant")

endmodule

bind best_fit_block_pool_core bfbp_checker u_bfbp_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.cmd_valid            (cmd.valid),
	.cmd_ready            (cmd.ready),
	.res_valid            (res.valid),
	.res_ready            (res.ready),
	.res_status           (res.status),
	.res_granted_size     (res.granted_size),
	.res_block_count      (res.block_count),
	.res_free_block_count (res.free_block_count)
);

/* tb/best_fit_block_pool_core_test.sv */
// Self-checking testbench for the best-fit block pool core.
// Drives command transactions, predicts every result transaction and compares them field by field.
// Depends on bfbp_pkg, the bfbp_if interfaces and best_fit_block_pool_core.
`timescale 1ns / 1ps

module best_fit_block_pool_core_test;
	import bfbp_pkg::*;

	localparam int POOL_SLOTS   = 16;
	localparam int SIZE_BITS    = 32;
	localparam int RANDOM_ITEMS = 1900;
	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AT      = 300;
	localparam int QUIET_FROM   = 900;
	localparam int QUIET_TO     = 1200;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   gslot;
		logic [REQ_W-1:0]    gsize;
		total_t              pool;
		total_t              used;
		logic [COUNT_W-1:0]  blocks;
		logic [COUNT_W-1:0]  free_blocks;
		event_cnt_t          grants;
		event_cnt_t          reuses;
	} pool_result_t;

	typedef struct packed {
		action_t             act;
		logic [REQ_W-1:0]    size;
		logic [SLOT_W-1:0]   slot;
		bit                  fixed;
		pool_result_t        reply;
	} command_row_t;

	logic clk;
	logic arst_n;

	bfbp_cmd_if cmd ();
	bfbp_res_if res ();

	best_fit_block_pool_core #(
		.MAX_BLOCKS(POOL_SLOTS),
		.SIZE_BITS (SIZE_BITS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd.sink),
		.res   (res.source)
	);

	// Shadow copy of the pool table and its totals.
	bit                slot_live  [POOL_SLOTS];
	bit                slot_taken [POOL_SLOTS];
	logic [REQ_W-1:0]  slot_bytes [POOL_SLOTS];
	total_t            held_bytes;
	total_t            taken_bytes;
	event_cnt_t        grant_total;
	event_cnt_t        reuse_total;

	pool_result_t      pending_replies[$];
	command_row_t      directed_rows[$];
	int                commands_sent;
	int                mismatches;
	int                status_seen[9];
	bit                quiet;

	function automatic total_t grow_total(total_t a, logic [REQ_W-1:0] b);
		logic [TOTAL_W:0] s;
		s = {1'b0, a} + b;
		return (s > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : s[TOTAL_W-1:0];
	endfunction

	function automatic total_t shrink_total(total_t a, logic [REQ_W-1:0] b);
		return (total_t'(b) > a) ? '0 : a - b;
	endfunction

	function automatic event_cnt_t bump_count(event_cnt_t c);
		return (c == EVENT_MAX) ? c : c + 1'b1;
	endfunction

	function automatic void clear_pool();
		int i;
		for (i = 0; i < POOL_SLOTS; i++) begin
			slot_live[i]  = 1'b0;
			slot_taken[i] = 1'b0;
		end
		held_bytes  = '0;
		taken_bytes = '0;
		grant_total = '0;
		reuse_total = '0;
	endfunction

	// Applies one command to the shadow table and returns the result it must produce.
	function automatic pool_result_t apply_pool_command(action_t act, logic [REQ_W-1:0] size,
			logic [SLOT_W-1:0] slot);
		pool_result_t r;
		int i;
		int best;
		int hole;
		r = '0;
		best = -1;
		hole = -1;
		case (act)
			ACT_ALLOC: begin
				if (size == '0) begin
					r.status = ST_ZERO;
				end else if ((64'(size) >> SIZE_BITS) != 0) begin
					r.status = ST_FULL;
				end else begin
					for (i = 0; i < POOL_SLOTS; i++) begin
						if (slot_live[i]) begin
							if (!slot_taken[i] && slot_bytes[i] >= size &&
									(best < 0 || slot_bytes[i] < slot_bytes[best]))
								best = i;
						end else if (hole < 0) begin
							hole = i;
						end
					end
					if (best >= 0) begin
						slot_taken[best] = 1'b1;
						taken_bytes = grow_total(taken_bytes, slot_bytes[best]);
						reuse_total = bump_count(reuse_total);
						grant_total = bump_count(grant_total);
						r.status = ST_REUSED;
						r.gslot  = best[SLOT_W-1:0];
						r.gsize  = slot_bytes[best];
					end else if (hole >= 0) begin
						slot_live[hole]  = 1'b1;
						slot_taken[hole] = 1'b1;
						slot_bytes[hole] = size;
						held_bytes  = grow_total(held_bytes, size);
						taken_bytes = grow_total(taken_bytes, size);
						grant_total = bump_count(grant_total);
						r.status = ST_NEW;
						r.gslot  = hole[SLOT_W-1:0];
						r.gsize  = size;
					end else begin
						r.status = ST_FULL;
					end
				end
			end
			ACT_RELEASE: begin
				if (int'(slot) >= POOL_SLOTS || !slot_live[slot]) begin
					r.status = ST_UNKNOWN;
				end else if (!slot_taken[slot]) begin
					r.status = ST_DOUBLE;
				end else begin
					slot_taken[slot] = 1'b0;
					taken_bytes = shrink_total(taken_bytes, slot_bytes[slot]);
					r.status = ST_RELEASED;
					r.gslot  = slot;
				end
			end
			ACT_RESET: begin
				clear_pool();
				r.status = ST_RESET;
			end
			default: begin
				for (i = 0; i < POOL_SLOTS; i++) begin
					if (slot_live[i] && !slot_taken[i]) begin
						slot_live[i] = 1'b0;
						held_bytes = shrink_total(held_bytes, slot_bytes[i]);
					end
				end
				r.status = ST_TRIMMED;
			end
		endcase
		for (i = 0; i < POOL_SLOTS; i++) begin
			if (slot_live[i]) begin
				r.blocks++;
				if (!slot_taken[i])
					r.free_blocks++;
			end
		end
		r.pool   = held_bytes;
		r.used   = taken_bytes;
		r.grants = grant_total;
		r.reuses = reuse_total;
		return r;
	endfunction

	function automatic pool_result_t make_reply(status_t st, int gslot, logic [REQ_W-1:0] gsize,
			total_t pool, total_t used, int blocks, int free_blocks, int grants, int reuses);
		pool_result_t r;
		r.status      = st;
		r.gslot       = gslot[SLOT_W-1:0];
		r.gsize       = gsize;
		r.pool        = pool;
		r.used        = used;
		r.blocks      = blocks[COUNT_W-1:0];
		r.free_blocks = free_blocks[COUNT_W-1:0];
		r.grants      = event_cnt_t'(grants);
		r.reuses      = event_cnt_t'(reuses);
		return r;
	endfunction

	function automatic void add_row(action_t act, logic [REQ_W-1:0] size, logic [SLOT_W-1:0] slot,
			bit fixed, pool_result_t reply);
		command_row_t row;
		row.act   = act;
		row.size  = size;
		row.slot  = slot;
		row.fixed = fixed;
		row.reply = reply;
		directed_rows.push_back(row);
	endfunction

	// Offers one command transaction and records its expected result once it is accepted.
	task automatic issue_command(action_t act, logic [REQ_W-1:0] size, logic [SLOT_W-1:0] slot,
			bit fixed, pool_result_t reply);
		pool_result_t predicted;
		if (!quiet) begin
			while ($urandom_range(99) < 13) begin
				cmd.valid <= 1'b0;
				@(posedge clk);
			end
		end
		cmd.valid        <= 1'b1;
		cmd.action       <= act;
		cmd.request_size <= size;
		cmd.slot         <= slot;
		do
			@(posedge clk);
		while (!cmd.ready);
		predicted = apply_pool_command(act, size, slot);
		pending_replies.push_back(fixed ? reply : predicted);
		commands_sent++;
	endtask

	task automatic check_field(string name, logic [63:0] expected, logic [63:0] actual);
		if (expected !== actual) begin
			$error("%s mismatch: expected %0h, got %0h", name, expected, actual);
			mismatches++;
		end
	endtask

	// Clock and reset.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Result side: random back-pressure, one long hold-off and a stretch with no idling.
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else if (!hold_done && commands_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				res.ready <= 1'b0;
			end else if (quiet) begin
				res.ready <= 1'b1;
			end else begin
				res.ready <= ($urandom_range(99) >= 13);
			end
		end
	end

	// Compares each accepted result transaction with the oldest expectation.
	always @(posedge clk) begin
		pool_result_t want;
		if (arst_n && res.valid && res.ready) begin
			if (pending_replies.size() == 0) begin
				$error("result transaction with no command waiting for it");
				mismatches++;
			end else begin
				want = pending_replies.pop_front();
				check_field("status", want.status, res.status);
				check_field("granted_slot", want.gslot, res.granted_slot);
				check_field("granted_size", want.gsize, res.granted_size);
				check_field("pool_bytes", want.pool, res.pool_bytes);
				check_field("used_bytes", want.used, res.used_bytes);
				check_field("block_count", want.blocks, res.block_count);
				check_field("free_block_count", want.free_blocks, res.free_block_count);
				check_field("grant_count", want.grants, res.grant_count);
				check_field("reuse_count", want.reuses, res.reuse_count);
				if (int'(res.status) < 9)
					status_seen[int'(res.status)]++;
			end
		end
	end

	// Watchdog: ends the run when neither channel moves for too long.
	always @(posedge clk) begin
		int still;
		if (!arst_n || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
			still = 0;
		end else begin
			still++;
			if (still >= STALL_LIMIT) begin
				$display("Timed out with %0d results outstanding", pending_replies.size());
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Command side: directed table first, then random traffic.
	initial begin
		int n;
		int pick;
		int busy[$];
		logic [REQ_W-1:0] size;
		logic [SLOT_W-1:0] slot;
		action_t act;
		int i;

		quiet = 1'b0;
		commands_sent = 0;
		mismatches = 0;
		clear_pool();
		cmd.valid        <= 1'b0;
		cmd.action       <= ACT_ALLOC;
		cmd.request_size <= '0;
		cmd.slot         <= '0;

		// Rows with a typed result start from an empty pool or follow directly from one.
		add_row(ACT_RELEASE, 32'd0, 4'd0, 1'b1,
			make_reply(ST_UNKNOWN, 0, '0, 36'h0, 36'h0, 0, 0, 0, 0));
		add_row(ACT_ALLOC, 32'd0, 4'd9, 1'b1,
			make_reply(ST_ZERO, 0, '0, 36'h0, 36'h0, 0, 0, 0, 0));
		add_row(ACT_ALLOC, 32'hFFFF_FFFF, 4'd15, 1'b1,
			make_reply(ST_NEW, 0, 32'hFFFF_FFFF, 36'h0_FFFF_FFFF, 36'h0_FFFF_FFFF, 1, 0, 1, 0));
		add_row(ACT_ALLOC, 32'd1, 4'd0, 1'b1,
			make_reply(ST_NEW, 1, 32'd1, 36'h1_0000_0000, 36'h1_0000_0000, 2, 0, 2, 0));
		add_row(ACT_RELEASE, 32'hFFFF_FFFF, 4'd0, 1'b1,
			make_reply(ST_RELEASED, 0, '0, 36'h1_0000_0000, 36'h1, 2, 1, 2, 0));
		add_row(ACT_RELEASE, 32'd0, 4'd0, 1'b1,
			make_reply(ST_DOUBLE, 0, '0, 36'h1_0000_0000, 36'h1, 2, 1, 2, 0));
		add_row(ACT_ALLOC, 32'd5, 4'd3, 1'b1,
			make_reply(ST_REUSED, 0, 32'hFFFF_FFFF, 36'h1_0000_0000, 36'h1_0000_0000,
				2, 0, 3, 1));
		add_row(ACT_RELEASE, 32'd0, 4'd15, 1'b1,
			make_reply(ST_UNKNOWN, 0, '0, 36'h1_0000_0000, 36'h1_0000_0000, 2, 0, 3, 1));
		add_row(ACT_TRIM, 32'd77, 4'd6, 1'b1,
			make_reply(ST_TRIMMED, 0, '0, 36'h1_0000_0000, 36'h1_0000_0000, 2, 0, 3, 1));
		// Best fit with ties: two sizes, each twice, then freed and asked for again.
		add_row(ACT_ALLOC, 32'd300, 4'd0, 1'b0, '0);
		add_row(ACT_ALLOC, 32'd200, 4'd0, 1'b0, '0);
		add_row(ACT_ALLOC, 32'd300, 4'd0, 1'b0, '0);
		add_row(ACT_ALLOC, 32'd200, 4'd0, 1'b0, '0);
		add_row(ACT_RELEASE, 32'd0, 4'd2, 1'b0, '0);
		add_row(ACT_RELEASE, 32'd0, 4'd3, 1'b0, '0);
		add_row(ACT_RELEASE, 32'd0, 4'd4, 1'b0, '0);
		add_row(ACT_RELEASE, 32'd0, 4'd5, 1'b0, '0);
		add_row(ACT_ALLOC, 32'd150, 4'd0, 1'b0, '0);
		add_row(ACT_ALLOC, 32'd250, 4'd0, 1'b0, '0);
		add_row(ACT_TRIM, 32'd0, 4'd0, 1'b0, '0);
		add_row(ACT_RESET, 32'hDEAD_BEEF, 4'd12, 1'b1,
			make_reply(ST_RESET, 0, '0, 36'h0, 36'h0, 0, 0, 0, 0));
		add_row(ACT_RELEASE, 32'd0, 4'd1, 1'b1,
			make_reply(ST_UNKNOWN, 0, '0, 36'h0, 36'h0, 0, 0, 0, 0));
		add_row(ACT_ALLOC, 32'd7, 4'd0, 1'b1,
			make_reply(ST_NEW, 0, 32'd7, 36'h7, 36'h7, 1, 0, 1, 0));

		@(posedge arst_n);
		@(posedge clk);

		foreach (directed_rows[k])
			issue_command(directed_rows[k].act, directed_rows[k].size, directed_rows[k].slot,
				directed_rows[k].fixed, directed_rows[k].reply);

		// Mostly allocations and releases of held blocks, with some noise mixed in.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (commands_sent >= QUIET_FROM && commands_sent < QUIET_TO);
			pick = $urandom_range(99);
			size = $urandom;
			slot = SLOT_W'($urandom_range(15));
			if (pick < 55) begin
				act = ACT_ALLOC;
				case ($urandom_range(9))
					7: size = $urandom;
					8: size = $urandom_range(4096, 1);
					9: size = {1'b1, 31'($urandom)};
					default: size = $urandom_range(64, 1);
				endcase
			end else if (pick < 85) begin
				act = ACT_RELEASE;
				busy.delete();
				for (i = 0; i < POOL_SLOTS; i++)
					if (slot_live[i] && slot_taken[i])
						busy.push_back(i);
				if (busy.size() != 0)
					slot = SLOT_W'(busy[$urandom_range(busy.size() - 1)]);
			end else if (pick < 92) begin
				act = ACT_RELEASE;
			end else if (pick < 96) begin
				act = ACT_ALLOC;
				size = '0;
			end else if (pick < 98) begin
				act = ACT_TRIM;
			end else begin
				act = ACT_RESET;
			end
			issue_command(act, size, slot, 1'b0, '0);
		end
		quiet = 1'b0;
		cmd.valid <= 1'b0;

		// Drain the outstanding results, then allow the block to settle.
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d commands: %0d reused, %0d new, %0d released, %0d full, %0d trims",
			commands_sent, status_seen[ST_REUSED], status_seen[ST_NEW],
			status_seen[ST_RELEASED], status_seen[ST_FULL], status_seen[ST_TRIMMED]);
		$display("Errors seen: %0d zero size, %0d double release, %0d unknown slot, %0d resets",
			status_seen[ST_ZERO], status_seen[ST_DOUBLE], status_seen[ST_UNKNOWN],
			status_seen[ST_RESET]);
		if (mismatches == 0 && pending_replies.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
